// ===== src/paced_sorted_packet_queue_macros.svh =====
// assertion helpers for the paced sorted packet queue
`ifndef PACED_SORTED_PACKET_QUEUE_MACROS_SVH
`define PACED_SORTED_PACKET_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psq check failed");

// next-cycle implication, checked outside reset
`define PSQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psq check failed");

`endif

// ===== src/psq_pkg.sv =====
package psq_pkg;

  localparam int QUEUE_DEPTH   = 32;
  localparam int SUBFLOW_COUNT = 16;
  localparam int OCC_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W         = 16;
  localparam int HANDLE_W      = 16;
  localparam int SUBFLOW_W     = 4;
  localparam int TIME_W        = 64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SET  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOT_DUE  = 3'd3,
    ST_POPPED   = 3'd4,
    ST_PACE_SET = 3'd5
  } status_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [HANDLE_W-1:0]   packet_handle;
    logic [KEY_W-1:0]      pace_key;
    logic [SUBFLOW_W-1:0]  flow_id;
    logic [TIME_W-1:0]     time_value;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   out_handle;
    logic [SUBFLOW_W-1:0]  out_subflow;
    logic                  now_empty;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [HANDLE_W-1:0]   handle;
    logic [SUBFLOW_W-1:0]  subflow;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  // a precedes b in serial-number order; a half-range gap counts as equal
  function automatic logic key_before(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b);
    logic [KEY_W-1:0] d;
    d = b - a;
    return (d != '0) && !d[KEY_W-1];
  endfunction

endpackage

// ===== src/paced_sorted_packet_queue.sv =====
// throughput: one operation per cycle unless a stalled result blocks the
//   input; a push inserts in a single pass of the cell row, a pop shifts the
//   row one place, both in the cycle of acceptance, with a registered result
// reset: synchronous, clears the occupancy, all pacing times and the
//   result valid; entry contents are not cleared
module paced_sorted_packet_queue import psq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic             due;
  cell_ctl_t        ctl;
  entry_t           new_ent;
  entry_t           ents  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] found;
  rsp_t             rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (occ == OCC_W'(QUEUE_DEPTH));
  assign empty     = (occ == '0);

  assign new_ent.key     = req.pace_key;
  assign new_ent.handle  = req.packet_handle;
  assign new_ent.subflow = req.flow_id;

  assign ctl.push = accept && (req.opcode == OP_PUSH) && !full;
  assign ctl.pop  = accept && (req.opcode == OP_POP) && !empty && due;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    if (i == 0) begin : g_first
      assign left_ent = new_ent;
    end else begin : g_mid
      assign left_ent = ents[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end
    psq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (occ > OCC_W'(i)),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .ent       (ents[i])
    );
  end

  psq_pace_table u_pace (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept && (req.opcode == OP_SET)),
    .wr_subflow (req.flow_id),
    .wr_time    (req.time_value),
    .rd_subflow (ents[0].subflow),
    .now        (req.time_value),
    .due        (due)
  );

  always_comb begin
    occ_next = occ;
    if (ctl.push) begin
      occ_next = occ + 1'b1;
    end else if (ctl.pop) begin
      occ_next = occ - 1'b1;
    end
  end

  always_comb begin
    rsp_next = '{status: ST_PUSHED, out_handle: '0, out_subflow: '0, now_empty: 1'b0};
    case (req.opcode)
      OP_PUSH: rsp_next.status = full ? ST_FULL : ST_PUSHED;
      OP_POP: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else if (!due) begin
          rsp_next.status = ST_NOT_DUE;
        end else begin
          rsp_next.status      = ST_POPPED;
          rsp_next.out_handle  = ents[0].handle;
          rsp_next.out_subflow = ents[0].subflow;
          rsp_next.now_empty   = (occ == OCC_W'(1));
        end
      end
      OP_SET:  rsp_next.status = ST_PACE_SET;
      default: rsp_next.status = ST_PUSHED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (accept && (req.opcode != OP_NONE)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result word only moves when a new one replaces it
  always_ff @(posedge clk) begin
    if (accept && (req.opcode != OP_NONE)) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/psq_cell.sv =====
module psq_cell import psq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      valid,
  input  entry_t    new_ent,
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  input  logic      found_in,
  output logic      found_out,
  output entry_t    ent
);

  logic hit;

  // first empty cell, or first held key not ahead of the new one
  assign hit       = !valid || !key_before(ent.key, new_ent.key);
  assign found_out = found_in || hit;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (found_in) begin
        ent <= left_ent;
      end else if (hit) begin
        ent <= new_ent;
      end
    end else if (ctl.pop) begin
      ent <= right_ent;
    end
  end

endmodule

// ===== src/psq_pace_table.sv =====
module psq_pace_table import psq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [SUBFLOW_W-1:0] wr_subflow,
  input  logic [TIME_W-1:0]    wr_time,
  input  logic [SUBFLOW_W-1:0] rd_subflow,
  input  logic [TIME_W-1:0]    now,
  output logic                 due
);

  logic [TIME_W-1:0] pace [SUBFLOW_COUNT];
  logic [TIME_W-1:0] pace_sel;

  // subflows outside the table read as time zero
  always_comb begin
    pace_sel = '0;
    for (int i = 0; i < SUBFLOW_COUNT; i++) begin
      if (32'(rd_subflow) == i) begin
        pace_sel = pace[i];
      end
    end
  end

  assign due = !(now < pace_sel);

  always_ff @(posedge clk) begin
    for (int i = 0; i < SUBFLOW_COUNT; i++) begin
      if (rst) begin
        pace[i] <= '0;
      end else if (wr_en && (32'(wr_subflow) == i)) begin
        pace[i] <= wr_time;
      end
    end
  end

endmodule

// ===== src/psq_checker.sv =====
`include "paced_sorted_packet_queue_macros.svh"

module psq_checker import psq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // stalled result word holds
  `PSQ_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // input only stalls behind a waiting result
  `PSQ_ASSERT_IMP(a_stall_cause, clk, rst, req_stall, rsp_valid && rsp_stall)

  // every real operation answers in the next cycle
  `PSQ_ASSERT_NXT(a_answer, clk, rst, req_valid && !req_stall && (req.opcode != OP_NONE), rsp_valid)

  // only a pop carries a handle, subflow or empty flag
  `PSQ_ASSERT_IMP(a_pop_fields, clk, rst, rsp_valid && (rsp.status != ST_POPPED), (rsp.out_handle == '0) && (rsp.out_subflow == '0) && !rsp.now_empty)

endmodule

bind paced_sorted_packet_queue psq_checker u_psq_checker (.*);

// ===== test/psq_order_checker.sv =====
`timescale 1ns / 100ps

module psq_order_checker import psq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   full_drops,
  output int   held_back,
  output int   drained
);

  localparam logic [KEY_W-1:0] HALF_RANGE = 16'h8000;

  entry_t            held [QUEUE_DEPTH];
  int                held_count;
  logic [TIME_W-1:0] release_time [SUBFLOW_COUNT];
  rsp_t              due_results [$];

  // serial-number order: a gap of exactly half the range ties
  function automatic logic sorts_ahead(input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
    logic [KEY_W-1:0] gap;
    gap = b - a;
    return (gap != '0) && (gap < HALF_RANGE);
  endfunction

  task automatic predict_result(input req_t w);
    rsp_t              r;
    int                slot;
    entry_t            head;
    entry_t            fresh;
    logic [TIME_W-1:0] ready_at;
    r = '0;
    case (w.opcode)
      OP_PUSH: begin
        if (held_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          slot = 0;
          // lands in front of the first entry that does not sort ahead of it
          while (slot < held_count && sorts_ahead(held[slot].key, w.pace_key))
            slot++;
          for (int i = held_count; i > slot; i--)
            held[i] = held[i-1];
          fresh.key     = w.pace_key;
          fresh.handle  = w.packet_handle;
          fresh.subflow = w.flow_id;
          held[slot] = fresh;
          held_count++;
          r.status = ST_PUSHED;
        end
      end
      OP_POP: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head = held[0];
          ready_at = (head.subflow < SUBFLOW_COUNT) ? release_time[head.subflow] : '0;
          if (w.time_value < ready_at) begin
            r.status = ST_NOT_DUE;
            held_back++;
          end else begin
            for (int i = 1; i < held_count; i++)
              held[i-1] = held[i];
            held_count--;
            r.status      = ST_POPPED;
            r.out_handle  = head.handle;
            r.out_subflow = head.subflow;
            r.now_empty   = (held_count == 0);
            if (held_count == 0)
              drained++;
          end
        end
      end
      OP_SET: begin
        if (w.flow_id < SUBFLOW_COUNT)
          release_time[w.flow_id] = w.time_value;
        r.status = ST_PACE_SET;
      end
      default: return;
    endcase
    due_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      held_count = 0;
      for (int i = 0; i < SUBFLOW_COUNT; i++)
        release_time[i] = '0;
      due_results.delete();
      fail_count = 0;
      checked    = 0;
      full_drops = 0;
      held_back  = 0;
      drained    = 0;
    end else begin
      if (req_valid && !req_stall)
        predict_result(req);
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual %h",
                   $time, rsp);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          compare_field("status", 16'(want.status), 16'(rsp.status));
          compare_field("out_handle", want.out_handle, rsp.out_handle);
          compare_field("out_subflow", 16'(want.out_subflow), 16'(rsp.out_subflow));
          compare_field("now_empty", 16'(want.now_empty), 16'(rsp.now_empty));
          checked++;
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== test/tb_paced_sorted_packet_queue.sv =====
`timescale 1ns / 100ps

module tb_paced_sorted_packet_queue;
  import psq_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int WORD_TARGET = 1850;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int fail_count, pending, checked, full_drops, held_back, drained;
  int idle_cycles  = 0;
  int stall_hold   = 0;
  int words_sent   = 0;
  int ignored_sent = 0;

  logic [TIME_W-1:0] clock_base;
  logic [KEY_W-1:0]  key_base;

  always #5 clk = ~clk;

  paced_sorted_packet_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  psq_order_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .full_drops (full_drops),
    .held_back  (held_back),
    .drained    (drained)
  );

  // result side back-pressure: mostly short bursts, the odd long stall,
  // now and then a long clear stretch
  always @(posedge clk) begin : stall_gen
    int unsigned roll;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        rsp_stall  <= 1'b0;
        stall_hold <= $urandom_range(50, 150);
      end else if (roll < 55) begin
        rsp_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 3);
      end else if (roll < 90) begin
        rsp_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (roll < 97) begin
        rsp_stall  <= 1'b1;
        stall_hold <= $urandom_range(4, 15);
      end else begin
        rsp_stall  <= 1'b1;
        stall_hold <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles with no word moving", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic req_t build_word(input opcode_t op, input logic [HANDLE_W-1:0] handle,
                                      input logic [KEY_W-1:0] key,
                                      input logic [SUBFLOW_W-1:0] sub,
                                      input logic [TIME_W-1:0] stamp);
    req_t w;
    w.opcode        = op;
    w.packet_handle = handle;
    w.pace_key      = key;
    w.flow_id       = sub;
    w.time_value    = stamp;
    return w;
  endfunction

  // times cluster round a base so that pops land both sides of the pacing times
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom, $urandom};
      default: return clock_base + $urandom_range(0, 64);
    endcase
  endfunction

  // keys cluster too, giving ties, half-range ties and wraparound
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      4, 5:    return KEY_W'(key_base + $urandom_range(0, 3));
      6:       return KEY_W'(key_base + 16'h8000 + $urandom_range(0, 1));
      7:       return KEY_W'(key_base - $urandom_range(0, 2));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic req_t random_word(input phase_t phase);
    int                roll;
    int                push_cut;
    int                pop_cut;
    logic [TIME_W-1:0] stamp;
    opcode_t           op;
    roll  = $urandom_range(0, 99);
    stamp = pick_time();
    case (phase)
      PH_FILL: begin
        push_cut = 75;
        pop_cut  = 85;
      end
      PH_DRAIN: begin
        push_cut = 10;
        pop_cut  = 85;
      end
      default: begin
        push_cut = 40;
        pop_cut  = 80;
      end
    endcase
    if (roll < push_cut) begin
      op = OP_PUSH;
    end else if (roll < pop_cut) begin
      op = OP_POP;
      if (phase == PH_DRAIN && $urandom_range(0, 9) < 7)
        stamp = '1;
    end else if (roll < 97) begin
      op = OP_SET;
    end else begin
      op = OP_NONE;
    end
    return build_word(op, HANDLE_W'($urandom), pick_key(),
                      SUBFLOW_W'($urandom_range(0, SUBFLOW_COUNT - 1)), stamp);
  endfunction

  task automatic send_word(input req_t w, input bit no_gaps);
    bit taken;
    int roll;
    int gap;
    req       <= w;
    req_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end
    if (w.opcode == OP_NONE)
      ignored_sent++;
    else
      words_sent++;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 50)
      gap = 0;
    else if (roll < 88)
      gap = $urandom_range(1, 3);
    else if (roll < 97)
      gap = $urandom_range(4, 12);
    else
      gap = $urandom_range(20, 60);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result word has come back
  task automatic settle();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] mark;
    phase_t            phase;
    int                span;
    bit                calm;
    clock_base = {$urandom, $urandom};
    key_base   = KEY_W'($urandom);
    mark       = 64'h8000_0000_0000_0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(build_word(OP_POP, 16'h0000, 16'h0000, 4'h0, '1), 1'b0);
    send_word(build_word(OP_NONE, 16'hFFFF, 16'hFFFF, 4'hF, '1), 1'b0);
    send_word(build_word(OP_SET, 16'h0000, 16'h0000, 4'h0, '1), 1'b0);
    send_word(build_word(OP_SET, 16'h0000, 16'h0000, 4'hF, '0), 1'b0);
    send_word(build_word(OP_SET, 16'h0000, 16'h0000, 4'h5, mark), 1'b0);
    send_word(build_word(OP_PUSH, 16'h0000, 16'h0000, 4'h0, '0), 1'b0);
    // half a range apart: ties with the key already held
    send_word(build_word(OP_PUSH, 16'hFFFF, 16'h8000, 4'hF, '0), 1'b0);
    send_word(build_word(OP_PUSH, 16'h1234, 16'hFFFF, 4'h5, '0), 1'b0);
    send_word(build_word(OP_PUSH, 16'hA5A5, 16'h0000, 4'h5, '0), 1'b0);
    send_word(build_word(OP_POP, 16'h0000, 16'h0000, 4'h0, '0), 1'b0);
    send_word(build_word(OP_POP, 16'h0000, 16'h0000, 4'h0, mark - 1), 1'b0);
    send_word(build_word(OP_POP, 16'h0000, 16'h0000, 4'h0, mark), 1'b0);
    send_word(build_word(OP_SET, 16'h0000, 16'h0000, 4'h0, '0), 1'b0);
    send_word(build_word(OP_POP, 16'h0000, 16'h0000, 4'h0, mark - 1), 1'b0);
    send_word(build_word(OP_POP, 16'h0000, 16'h0000, 4'h0, mark), 1'b0);
    repeat (5)
      send_word(build_word(OP_POP, 16'h0000, 16'h0000, 4'h0, '1), 1'b0);
    settle();

    while (words_sent < WORD_TARGET) begin
      phase    = phase_t'($urandom_range(0, 2));
      span     = $urandom_range(40, 160);
      calm     = ($urandom_range(0, 3) == 0);
      key_base = KEY_W'($urandom);
      repeat (span)
        send_word(random_word(phase), calm);
      if ($urandom_range(0, 2) == 0)
        settle();
    end

    settle();
    repeat (20) @(posedge clk);
    $display("sent %0d words plus %0d with the unused opcode; %0d results checked",
             words_sent, ignored_sent, checked);
    $display("pushes dropped on a full queue %0d, pops held back by pacing %0d, %s %0d",
             full_drops, held_back, "pops that left the queue empty", drained);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/psq_pkg.sv
src/psq_cell.sv
src/psq_pace_table.sv
src/paced_sorted_packet_queue.sv
src/psq_checker.sv
test/psq_order_checker.sv
test/tb_paced_sorted_packet_queue.sv
